// File: rtl/sfcd_pkg.sv
// Shared types and constants for the frame channel decoder.
package sfcd_pkg;

    localparam int FRAME_LEN = 25;
    localparam int STORE_LEN = 15;
    localparam int NUM_CH    = 10;
    localparam int CH_W      = 11;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h00;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CNT_W-1:0] TIMEOUT_RST  = 16'd500;
    localparam logic [CH_W-1:0]  FAILSAFE_RST = 11'd1000;
    localparam logic [CH_W-1:0]  ARM_RST      = 11'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM      = 2'd2;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chan_arr;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] channel_1;
        logic [CH_W-1:0] channel_2;
        logic [CH_W-1:0] channel_3;
        logic [CH_W-1:0] channel_4;
        logic [CH_W-1:0] channel_5;
        logic [CH_W-1:0] channel_6;
        logic [CH_W-1:0] channel_7;
        logic [CH_W-1:0] channel_8;
        logic [CH_W-1:0] channel_9;
        logic [CH_W-1:0] channel_10;
        logic            connected;
        logic            armed;
    } t_out_item;

    // Frame assembler status toward the link controller
    typedef struct packed {
        logic frame_done;
        logic frame_good;
    } t_frame_stat;

endpackage

// File: rtl/sbus_frame_channel_decoder.sv
// A request is held in the input register; when it advances, its result (if any)
// is loaded into the result register at that same edge.
// Throughput: one request per cycle; the input stage drains whenever the result
// register is empty or being taken.
// Reset: synchronous, active low; no frame open, link down, channels zero,
// registers at 500 / 1000 / 500.
module sbus_frame_channel_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sfcd_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sfcd_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [sfcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                         r_in_valid;
    sfcd_pkg::t_in_item           r_in;
    logic                         advance;
    logic                         timeout;
    sfcd_pkg::t_frame_stat        stat;
    sfcd_pkg::t_chan_arr          chan;
    logic [sfcd_pkg::CNT_W-1:0]   r_timeout_ticks;
    logic [sfcd_pkg::CH_W-1:0]    r_failsafe_value;
    logic [sfcd_pkg::CH_W-1:0]    r_arm_limit;

    // Advance the held request when the result slot is free or draining
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks  <= sfcd_pkg::TIMEOUT_RST;
            r_failsafe_value <= sfcd_pkg::FAILSAFE_RST;
            r_arm_limit      <= sfcd_pkg::ARM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfcd_pkg::CFG_TIMEOUT:  r_timeout_ticks  <= i_cfg_data;
                sfcd_pkg::CFG_FAILSAFE: r_failsafe_value <= i_cfg_data[sfcd_pkg::CH_W-1:0];
                sfcd_pkg::CFG_ARM:      r_arm_limit      <= i_cfg_data[sfcd_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    sfcd_frame_asm u_frame_asm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_step   (advance && r_in.op == sfcd_pkg::OP_BYTE),
        .i_data_byte   (r_in.data_byte),
        .i_frame_start (r_in.frame_start),
        .i_close       (timeout),
        .o_stat        (stat),
        .o_chan        (chan)
    );

    sfcd_link_ctrl u_link_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_tick           (r_in.op == sfcd_pkg::OP_TICK),
        .i_stat           (stat),
        .i_chan           (chan),
        .i_timeout_ticks  (r_timeout_ticks),
        .i_failsafe_value (r_failsafe_value),
        .i_arm_limit      (r_arm_limit),
        .i_out_ready      (i_out_ready),
        .o_timeout        (timeout),
        .o_out_valid      (o_out_valid),
        .o_out_data       (o_out_data)
    );

endmodule

// File: rtl/sfcd_frame_asm.sv
// Byte collection into a frame store, frame check and channel unpacking.
module sfcd_frame_asm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_start,
    input  logic                 i_close,
    output sfcd_pkg::t_frame_stat o_stat,
    output sfcd_pkg::t_chan_arr  o_chan
);

    localparam int STORE_IDX_W = $clog2(sfcd_pkg::STORE_LEN);

    logic [sfcd_pkg::POS_W-1:0] r_pos;
    logic [sfcd_pkg::POS_W-1:0] n_pos;
    logic [sfcd_pkg::POS_W-1:0] cur_pos;
    logic [7:0]                 r_store [sfcd_pkg::STORE_LEN];
    logic                       open_pos;
    logic [(sfcd_pkg::STORE_LEN-1)*8-1:0] packed_bits;

    assign cur_pos  = i_frame_start ? '0 : r_pos;
    assign open_pos = cur_pos < sfcd_pkg::POS_W'(sfcd_pkg::FRAME_LEN);

    always_comb begin
        n_pos = r_pos;
        if (i_close) begin
            n_pos = sfcd_pkg::POS_W'(sfcd_pkg::FRAME_LEN);
        end else if (i_byte_step && open_pos) begin
            n_pos = cur_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sfcd_pkg::POS_W'(sfcd_pkg::FRAME_LEN);
        end else begin
            r_pos <= n_pos;
        end
    end

    // Only header and channel bytes are kept; the end byte is checked on arrival
    always_ff @(posedge i_clk) begin
        if (i_byte_step && cur_pos < sfcd_pkg::POS_W'(sfcd_pkg::STORE_LEN)) begin
            r_store[cur_pos[STORE_IDX_W-1:0]] <= i_data_byte;
        end
    end

    always_comb begin
        o_stat.frame_done = i_byte_step
                          && cur_pos == sfcd_pkg::POS_W'(sfcd_pkg::FRAME_LEN - 1);
        o_stat.frame_good = o_stat.frame_done
                          && r_store[0] == sfcd_pkg::HEADER_BYTE
                          && i_data_byte == sfcd_pkg::END_BYTE;
    end

    // Channels are packed little-endian, 11 bits each, from byte 1 up
    always_comb begin
        for (int b = 1; b < sfcd_pkg::STORE_LEN; b++) begin
            packed_bits[(b-1)*8 +: 8] = r_store[b];
        end
        for (int c = 0; c < sfcd_pkg::NUM_CH; c++) begin
            o_chan[c] = packed_bits[c*sfcd_pkg::CH_W +: sfcd_pkg::CH_W];
        end
    end

endmodule

// File: rtl/sfcd_link_ctrl.sv
// Silence counter, failsafe, channel state and result register.
module sfcd_link_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_tick,
    input  sfcd_pkg::t_frame_stat         i_stat,
    input  sfcd_pkg::t_chan_arr           i_chan,
    input  logic [sfcd_pkg::CNT_W-1:0]    i_timeout_ticks,
    input  logic [sfcd_pkg::CH_W-1:0]     i_failsafe_value,
    input  logic [sfcd_pkg::CH_W-1:0]     i_arm_limit,
    input  logic                          i_out_ready,
    output logic                          o_timeout,
    output logic                          o_out_valid,
    output sfcd_pkg::t_out_item           o_out_data
);

    logic [sfcd_pkg::CNT_W-1:0] r_silence;
    logic [sfcd_pkg::CNT_W-1:0] n_silence;
    logic [sfcd_pkg::CNT_W-1:0] inc_silence;
    logic [sfcd_pkg::CNT_W-1:0] limit;
    sfcd_pkg::t_chan_arr        r_ch;
    sfcd_pkg::t_chan_arr        n_ch;
    logic                       r_link;
    logic                       n_link;
    logic                       n_armed;
    logic                       emit;
    logic                       r_out_valid;
    sfcd_pkg::t_out_item        r_out;

    assign inc_silence = (&r_silence) ? r_silence : r_silence + 1'b1;
    assign limit       = (i_timeout_ticks == '0) ? sfcd_pkg::CNT_W'(1) : i_timeout_ticks;
    assign o_timeout   = i_step && i_tick && inc_silence >= limit;

    always_comb begin
        n_silence = r_silence;
        n_ch      = r_ch;
        n_link    = r_link;
        if (i_step && i_tick) begin
            n_silence = o_timeout ? '0 : inc_silence;
            if (o_timeout) begin
                for (int c = 0; c < 4; c++) begin
                    n_ch[c] = i_failsafe_value;
                end
                n_link = 1'b0;
            end
        end else if (i_stat.frame_done) begin
            n_silence = '0;
            if (i_stat.frame_good) begin
                n_ch   = i_chan;
                n_link = 1'b1;
            end
        end
    end

    assign emit    = o_timeout || i_stat.frame_good;
    assign n_armed = n_link && n_ch[6] < i_arm_limit && n_ch[7] < i_arm_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence   <= '0;
            r_ch        <= '0;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_silence <= n_silence;
            r_ch      <= n_ch;
            r_link    <= n_link;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.channel_1  <= n_ch[0];
            r_out.channel_2  <= n_ch[1];
            r_out.channel_3  <= n_ch[2];
            r_out.channel_4  <= n_ch[3];
            r_out.channel_5  <= n_ch[4];
            r_out.channel_6  <= n_ch[5];
            r_out.channel_7  <= n_ch[6];
            r_out.channel_8  <= n_ch[7];
            r_out.channel_9  <= n_ch[8];
            r_out.channel_10 <= n_ch[9];
            r_out.connected  <= n_link;
            r_out.armed      <= n_armed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
